@@ hw/rtl/tbp_pkg.sv @@
// ----------------------------------------------------------------------------
// tbp_pkg
// Sizes, types and counter helpers of the tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

   localparam int PC_BITS             = 64;
   localparam int PC_INDEX_BITS       = 10;
   localparam int LOCAL_HISTORY_BITS  = 10;
   localparam int GLOBAL_HISTORY_BITS = 12;
   localparam int LOCAL_COUNTER_BITS  = 3;
   localparam int CHOOSER_BITS        = 2;
   localparam int GLOBAL_COUNTER_BITS = 2;

   localparam int REQ_TDATA_BITS = ((PC_BITS + 1 + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = 8;

   localparam int LH_DEPTH = 1 << PC_INDEX_BITS;
   localparam int LC_DEPTH = 1 << LOCAL_HISTORY_BITS;
   localparam int G_DEPTH  = 1 << GLOBAL_HISTORY_BITS;

   localparam int CLR_BITS_A = (PC_INDEX_BITS > LOCAL_HISTORY_BITS) ?
                               PC_INDEX_BITS : LOCAL_HISTORY_BITS;
   localparam int CLR_BITS   = (CLR_BITS_A > GLOBAL_HISTORY_BITS) ?
                               CLR_BITS_A : GLOBAL_HISTORY_BITS;

   typedef logic [PC_INDEX_BITS-1:0]       slot_type;
   typedef logic [LOCAL_HISTORY_BITS-1:0]  lhist_type;
   typedef logic [GLOBAL_HISTORY_BITS-1:0] ghist_type;
   typedef logic [LOCAL_COUNTER_BITS-1:0]  lctr_type;
   typedef logic [CHOOSER_BITS-1:0]        chctr_type;
   typedef logic [GLOBAL_COUNTER_BITS-1:0] gctr_type;
   typedef logic [CLR_BITS-1:0]            clr_type;

   function automatic lctr_type lctr_step(lctr_type v, logic up);
      lctr_type r;
      r = v;
      if (up && (v != {LOCAL_COUNTER_BITS{1'b1}})) begin
         r = v + lctr_type'(1);
      end else if (!up && (v != '0)) begin
         r = v - lctr_type'(1);
      end
      return r;
   endfunction

   function automatic chctr_type chctr_step(chctr_type v, logic up);
      chctr_type r;
      r = v;
      if (up && (v != {CHOOSER_BITS{1'b1}})) begin
         r = v + chctr_type'(1);
      end else if (!up && (v != '0)) begin
         r = v - chctr_type'(1);
      end
      return r;
   endfunction

   function automatic gctr_type gctr_step(gctr_type v, logic up);
      gctr_type r;
      r = v;
      if (up && (v != {GLOBAL_COUNTER_BITS{1'b1}})) begin
         r = v + gctr_type'(1);
      end else if (!up && (v != '0)) begin
         r = v - gctr_type'(1);
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/tournament_branch_predictor_top.sv @@
// ----------------------------------------------------------------------------
// tournament_branch_predictor_top
// Local/global tournament predictor: predicts and trains per branch, then reports.
// A request passes through stage 1, stage 2 and the output register to rsp_tvalid.
// Throughput: one transaction per cycle while rsp_tready is high.
// Reset: a clearing pass over 2**CLR_BITS (4096) counter values zeroes all tables,
// one entry per cycle; req_tready stays low until it completes.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tbp_pkg::REQ_TDATA_BITS-1:0]  req_tdata,  // pc[63:0], taken[64], zero pad
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tbp_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata   // prediction[0], used_local[1], zero pad
);

   // tables
   tbp_pkg::lhist_type lh_mem [tbp_pkg::LH_DEPTH];
   tbp_pkg::lctr_type  lc_mem [tbp_pkg::LC_DEPTH];
   tbp_pkg::chctr_type ch_mem [tbp_pkg::G_DEPTH];
   tbp_pkg::gctr_type  gc_mem [tbp_pkg::G_DEPTH];

   logic               clearing_ff;
   tbp_pkg::clr_type   clr_cnt_ff;
   tbp_pkg::ghist_type gh_ff;

   logic               adv;
   logic               req_acc;
   tbp_pkg::slot_type  req_slot;
   logic               req_taken;

   // stage 1
   logic               s1_valid_ff;
   tbp_pkg::slot_type  s1_slot_ff;
   logic               s1_taken_ff;
   tbp_pkg::ghist_type s1_gidx_ff;
   tbp_pkg::lhist_type lh_q_ff;
   tbp_pkg::lhist_type lh_cur;
   tbp_pkg::lhist_type lh_in;

   // stage 2
   logic               s2_valid_ff;
   logic               s2_taken_ff;
   tbp_pkg::ghist_type s2_gidx_ff;
   tbp_pkg::lhist_type s2_lidx_ff;
   tbp_pkg::lctr_type  lc_q_ff;
   tbp_pkg::chctr_type ch_q_ff;
   tbp_pkg::gctr_type  gc_q_ff;
   tbp_pkg::lctr_type  lc_cur;
   tbp_pkg::chctr_type ch_cur;
   tbp_pkg::gctr_type  gc_cur;
   logic               use_local;
   logic               pred;
   tbp_pkg::lctr_type  lc_in;
   tbp_pkg::chctr_type ch_in;
   tbp_pkg::gctr_type  gc_in;

   // last write of each table, for the one transaction the registered read misses
   logic               lh_lw_valid_ff;
   tbp_pkg::slot_type  lh_lw_addr_ff;
   tbp_pkg::lhist_type lh_lw_data_ff;
   logic               lc_lw_valid_ff;
   tbp_pkg::lhist_type lc_lw_addr_ff;
   tbp_pkg::lctr_type  lc_lw_data_ff;
   logic               ch_lw_valid_ff;
   tbp_pkg::ghist_type ch_lw_addr_ff;
   tbp_pkg::chctr_type ch_lw_data_ff;
   logic               gc_lw_valid_ff;
   tbp_pkg::ghist_type gc_lw_addr_ff;
   tbp_pkg::gctr_type  gc_lw_data_ff;

   // output register
   logic               rsp_valid_ff;
   logic               rsp_pred_ff;
   logic               rsp_local_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = !clearing_ff && adv;
   assign req_acc    = req_tvalid && req_tready;
   assign req_slot   = req_tdata[tbp_pkg::PC_INDEX_BITS-1:0];
   assign req_taken  = req_tdata[tbp_pkg::PC_BITS];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tbp_pkg::RSP_TDATA_BITS-2){1'b0}}, rsp_local_ff, rsp_pred_ff};

   // stage 1 logic
   always_comb begin
      lh_cur = (lh_lw_valid_ff && (lh_lw_addr_ff == s1_slot_ff)) ? lh_lw_data_ff : lh_q_ff;
      lh_in  = {s1_taken_ff, lh_cur[tbp_pkg::LOCAL_HISTORY_BITS-1:1]};
   end

   // stage 2 logic
   always_comb begin
      lc_cur    = (lc_lw_valid_ff && (lc_lw_addr_ff == s2_lidx_ff)) ? lc_lw_data_ff : lc_q_ff;
      ch_cur    = (ch_lw_valid_ff && (ch_lw_addr_ff == s2_gidx_ff)) ? ch_lw_data_ff : ch_q_ff;
      gc_cur    = (gc_lw_valid_ff && (gc_lw_addr_ff == s2_gidx_ff)) ? gc_lw_data_ff : gc_q_ff;
      use_local = ch_cur[tbp_pkg::CHOOSER_BITS-1];
      pred      = use_local ? lc_cur[tbp_pkg::LOCAL_COUNTER_BITS-1]
                            : gc_cur[tbp_pkg::GLOBAL_COUNTER_BITS-1];
      lc_in     = tbp_pkg::lctr_step(lc_cur, s2_taken_ff);
      gc_in     = tbp_pkg::gctr_step(gc_cur, s2_taken_ff);
      ch_in     = tbp_pkg::chctr_step(ch_cur, (pred == s2_taken_ff) == use_local);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff    <= 1'b1;
         clr_cnt_ff     <= '0;
         gh_ff          <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         lh_lw_valid_ff <= 1'b0;
         lc_lw_valid_ff <= 1'b0;
         ch_lw_valid_ff <= 1'b0;
         gc_lw_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + tbp_pkg::clr_type'(1);
            if (clr_cnt_ff == {tbp_pkg::CLR_BITS{1'b1}}) begin
               clearing_ff <= 1'b0;
            end
         end
         if (req_acc) begin
            gh_ff <= {req_taken, gh_ff[tbp_pkg::GLOBAL_HISTORY_BITS-1:1]};
         end
         if (adv) begin
            s1_valid_ff    <= req_acc;
            s2_valid_ff    <= s1_valid_ff;
            rsp_valid_ff   <= s2_valid_ff;
            lh_lw_valid_ff <= s1_valid_ff;
            lc_lw_valid_ff <= s2_valid_ff && use_local;
            ch_lw_valid_ff <= s2_valid_ff;
            gc_lw_valid_ff <= s2_valid_ff && !use_local;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_slot_ff    <= req_slot;
         s1_taken_ff   <= req_taken;
         s1_gidx_ff    <= gh_ff;
         s2_taken_ff   <= s1_taken_ff;
         s2_gidx_ff    <= s1_gidx_ff;
         s2_lidx_ff    <= lh_cur;
         lh_lw_addr_ff <= s1_slot_ff;
         lh_lw_data_ff <= lh_in;
         lc_lw_addr_ff <= s2_lidx_ff;
         lc_lw_data_ff <= lc_in;
         ch_lw_addr_ff <= s2_gidx_ff;
         ch_lw_data_ff <= ch_in;
         gc_lw_addr_ff <= s2_gidx_ff;
         gc_lw_data_ff <= gc_in;
         rsp_pred_ff   <= pred;
         rsp_local_ff  <= use_local;
      end
   end

   // local history table
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         lh_mem[clr_cnt_ff[tbp_pkg::PC_INDEX_BITS-1:0]] <= '0;
      end else if (adv && s1_valid_ff) begin
         lh_mem[s1_slot_ff] <= lh_in;
      end
      if (adv) begin
         lh_q_ff <= lh_mem[req_slot];
      end
   end

   // local counter table
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         lc_mem[clr_cnt_ff[tbp_pkg::LOCAL_HISTORY_BITS-1:0]] <= '0;
      end else if (adv && s2_valid_ff && use_local) begin
         lc_mem[s2_lidx_ff] <= lc_in;
      end
      if (adv) begin
         lc_q_ff <= lc_mem[lh_cur];
      end
   end

   // chooser table
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         ch_mem[clr_cnt_ff[tbp_pkg::GLOBAL_HISTORY_BITS-1:0]] <= '0;
      end else if (adv && s2_valid_ff) begin
         ch_mem[s2_gidx_ff] <= ch_in;
      end
      if (adv) begin
         ch_q_ff <= ch_mem[s1_gidx_ff];
      end
   end

   // global counter table
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         gc_mem[clr_cnt_ff[tbp_pkg::GLOBAL_HISTORY_BITS-1:0]] <= '0;
      end else if (adv && s2_valid_ff && !use_local) begin
         gc_mem[s2_gidx_ff] <= gc_in;
      end
      if (adv) begin
         gc_q_ff <= gc_mem[s1_gidx_ff];
      end
   end

   // checks
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> (!s1_valid_ff && !s2_valid_ff && !rsp_valid_ff))
      else $error("pipeline busy during clearing pass");

   a_gh_shift: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (gh_ff[tbp_pkg::GLOBAL_HISTORY_BITS-1] == $past(req_taken)))
      else $error("global history did not take outcome");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(s1_valid_ff) && $stable(s2_valid_ff) && $stable(rsp_pred_ff)))
      else $error("pipeline moved while output stalled");

   a_clear_len: assert property (@(posedge clock) disable iff (reset)
      $fell(clearing_ff) |-> ($past(clr_cnt_ff) == {tbp_pkg::CLR_BITS{1'b1}}))
      else $error("clearing pass ended early");

   a_one_table: assert property (@(posedge clock) disable iff (reset)
      adv |=> !(lc_lw_valid_ff && gc_lw_valid_ff))
      else $error("both components trained for one transaction");

endmodule
